// ----- src/keyed_record_table_assert.svh -----
// ----------------------------------------------------------------------------
// keyed_record_table assertion macros
// Shared property forms for the record table checks.
// ----------------------------------------------------------------------------
`ifndef KEYED_RECORD_TABLE_ASSERT_SVH
`define KEYED_RECORD_TABLE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define KRT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define KRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/krt_pkg.sv -----
// ----------------------------------------------------------------------------
// krt_pkg
// Shared types and constants for the keyed record table.
// ----------------------------------------------------------------------------
package krt_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_LIST   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // Source of the record fed back into the tail cell of the ring.
  localparam logic [1:0] FB_HEAD = 2'd0;
  localparam logic [1:0] FB_NEXT = 2'd1;
  localparam logic [1:0] FB_NEW  = 2'd2;

  typedef struct packed {
    logic [31:0] key;
    logic [15:0] year;
    logic [15:0] subject_a;
    logic [15:0] subject_b;
    logic [15:0] subject_c;
    logic [7:0]  grade_a;
    logic [7:0]  grade_b;
    logic [7:0]  grade_c;
  } rec_t;

  typedef struct packed {
    logic       shift;
    logic [1:0] fb_sel;
  } chain_ctl_t;

endpackage

// ----- src/krt_cell.sv -----
// ----------------------------------------------------------------------------
// krt_cell
// One slot of the record ring: holds a record and takes its neighbour's on a shift.
// ----------------------------------------------------------------------------
module krt_cell (
  input  logic          clk,
  input  logic          shift,
  input  krt_pkg::rec_t rec_in,
  output krt_pkg::rec_t rec_q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      rec_q <= rec_in;
    end
  end

endmodule

// ----- src/krt_chain.sv -----
// ----------------------------------------------------------------------------
// krt_chain
// Ring of record cells rotating towards the head, with a selectable tail feed.
// ----------------------------------------------------------------------------
module krt_chain (
  input  logic                clk,
  input  krt_pkg::chain_ctl_t ctl,
  input  krt_pkg::rec_t       new_rec,
  output krt_pkg::rec_t       head
);

  krt_pkg::rec_t cell_q [krt_pkg::CAPACITY];
  krt_pkg::rec_t feed;

  // After a full turn the record fed back at step s lands in slot s, so
  // choosing the feed per step appends, removes or keeps records in place.
  always_comb begin
    unique case (ctl.fb_sel)
      krt_pkg::FB_NEXT: feed = cell_q[1];
      krt_pkg::FB_NEW:  feed = new_rec;
      default:          feed = cell_q[0];
    endcase
  end

  for (genvar k = 0; k < krt_pkg::CAPACITY; k++) begin : g_cell
    if (k == krt_pkg::CAPACITY - 1) begin : g_tail
      krt_cell u_cell (
        .clk    (clk),
        .shift  (ctl.shift),
        .rec_in (feed),
        .rec_q  (cell_q[k])
      );
    end else begin : g_body
      krt_cell u_cell (
        .clk    (clk),
        .shift  (ctl.shift),
        .rec_in (cell_q[k+1]),
        .rec_q  (cell_q[k])
      );
    end
  end

  assign head = cell_q[0];

endmodule

// ----- src/keyed_record_table.sv -----
// ----------------------------------------------------------------------------
// keyed_record_table
// Bounded insertion-ordered table of keyed records with add, delete, lookup
// and list requests.
// ----------------------------------------------------------------------------
// Usage: a request (opcode, key and record fields) enters on in_valid/in_ready
// and its results leave on out_valid/out_ready through a single output
// register. Every request turns the record ring once, one step per cycle
// while the output side keeps up, and occupies the block from its acceptance
// to the end of the turn; in_ready returns the cycle after the last step, so
// no new request is taken before the last one is through. Add, delete and
// lookup give one result at the end of the turn. List gives one result per
// held key, one per step, the first at the first step and the last marked by
// last_item; on an empty table it gives a single not-found result.
// The turn of the ring sets the rate.
// A stalled receiver freezes the ring: no step is taken while a result sits
// unaccepted in the output register, so nothing is dropped. A result may wait
// in the output register while the next request is being accepted.
// Reset empties the table (count zero); record contents are not cleared.
// ----------------------------------------------------------------------------
module keyed_record_table (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                opcode,
  input  logic [31:0]               key,
  input  logic [15:0]               year_in,
  input  logic [15:0]               subject_a_in,
  input  logic [15:0]               subject_b_in,
  input  logic [15:0]               subject_c_in,
  input  logic [7:0]                grade_a_in,
  input  logic [7:0]                grade_b_in,
  input  logic [7:0]                grade_c_in,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                status,
  output logic [31:0]               key_out,
  output logic [15:0]               year_out,
  output logic [15:0]               subject_a_out,
  output logic [15:0]               subject_b_out,
  output logic [15:0]               subject_c_out,
  output logic [7:0]                grade_a_out,
  output logic [7:0]                grade_b_out,
  output logic [7:0]                grade_c_out,
  output logic [krt_pkg::CNT_W-1:0] used_count,
  output logic                      is_full,
  output logic                      last_item
);

  logic                      busy;
  logic [krt_pkg::IDX_W-1:0] step;
  logic [1:0]                op_q;
  logic [31:0]               probe;
  krt_pkg::rec_t             new_rec;
  logic [krt_pkg::CNT_W-1:0] count;
  logic                      found;
  krt_pkg::rec_t             hit_rec;

  krt_pkg::rec_t             out_rec;
  logic [1:0]                out_status;
  logic                      out_last;
  logic [krt_pkg::CNT_W-1:0] out_count;

  krt_pkg::rec_t             head;
  krt_pkg::chain_ctl_t       ctl;

  logic                      can_step;
  logic                      last_step;
  logic                      head_live;
  logic                      match_now;
  logic                      found_f;
  logic                      table_full;
  logic [krt_pkg::CNT_W-1:0] step_w;
  logic                      emit;
  krt_pkg::rec_t             emit_rec;
  logic [1:0]                emit_status;
  logic                      emit_last;
  logic [krt_pkg::CNT_W-1:0] count_next;

  krt_chain u_chain (
    .clk     (clk),
    .ctl     (ctl),
    .new_rec (new_rec),
    .head    (head)
  );

  assign in_ready   = !busy;
  assign can_step   = busy && (!out_valid || out_ready);
  assign last_step  = step == krt_pkg::IDX_W'(krt_pkg::CAPACITY - 1);
  assign step_w     = krt_pkg::CNT_W'(step);
  assign head_live  = step_w < count;
  assign table_full = count == krt_pkg::CNT_W'(krt_pkg::CAPACITY);
  assign match_now  = (op_q == krt_pkg::OP_DELETE || op_q == krt_pkg::OP_LOOKUP) &&
                      head_live && !found && (head.key == probe);
  assign found_f    = found || match_now;

  always_comb begin
    ctl.shift  = can_step;
    ctl.fb_sel = krt_pkg::FB_HEAD;
    if (op_q == krt_pkg::OP_ADD && !table_full && step_w == count) begin
      ctl.fb_sel = krt_pkg::FB_NEW;
    end else if (op_q == krt_pkg::OP_DELETE && found_f) begin
      ctl.fb_sel = krt_pkg::FB_NEXT;
    end
  end

  always_comb begin
    emit        = 1'b0;
    emit_rec    = '0;
    emit_status = krt_pkg::ST_OK;
    emit_last   = 1'b1;
    count_next  = count;
    unique case (op_q)
      krt_pkg::OP_ADD: begin
        emit = last_step;
        if (table_full) begin
          emit_status = krt_pkg::ST_FULL;
        end else begin
          count_next = count + krt_pkg::CNT_W'(1);
        end
      end
      krt_pkg::OP_DELETE: begin
        emit = last_step;
        if (found_f) begin
          count_next = count - krt_pkg::CNT_W'(1);
        end else begin
          emit_status = krt_pkg::ST_NOT_FOUND;
        end
      end
      krt_pkg::OP_LOOKUP: begin
        emit = last_step;
        if (match_now) begin
          emit_rec = head;
        end else if (found) begin
          emit_rec = hit_rec;
        end else begin
          emit_status = krt_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        if (head_live) begin
          emit         = 1'b1;
          emit_rec.key = head.key;
          emit_last    = (step_w + krt_pkg::CNT_W'(1)) == count;
        end else if (count == '0) begin
          emit        = last_step;
          emit_status = krt_pkg::ST_NOT_FOUND;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= '0;
      count     <= '0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        busy  <= 1'b1;
        step  <= '0;
        found <= 1'b0;
      end else if (can_step) begin
        step <= step + krt_pkg::IDX_W'(1);
        if (match_now) begin
          found <= 1'b1;
        end
        if (last_step) begin
          busy  <= 1'b0;
          count <= count_next;
        end
      end

      if (can_step && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q              <= opcode;
      probe             <= key;
      new_rec.key       <= key;
      new_rec.year      <= year_in;
      new_rec.subject_a <= subject_a_in;
      new_rec.subject_b <= subject_b_in;
      new_rec.subject_c <= subject_c_in;
      new_rec.grade_a   <= grade_a_in;
      new_rec.grade_b   <= grade_b_in;
      new_rec.grade_c   <= grade_c_in;
    end
    if (can_step && match_now) begin
      hit_rec <= head;
    end
    if (can_step && emit) begin
      out_rec    <= emit_rec;
      out_status <= emit_status;
      out_last   <= emit_last;
      out_count  <= last_step ? count_next : count;
    end
  end

  assign status        = out_status;
  assign key_out       = out_rec.key;
  assign year_out      = out_rec.year;
  assign subject_a_out = out_rec.subject_a;
  assign subject_b_out = out_rec.subject_b;
  assign subject_c_out = out_rec.subject_c;
  assign grade_a_out   = out_rec.grade_a;
  assign grade_b_out   = out_rec.grade_b;
  assign grade_c_out   = out_rec.grade_c;
  assign used_count    = out_count;
  assign is_full       = out_count == krt_pkg::CNT_W'(krt_pkg::CAPACITY);
  assign last_item     = out_last;

  `include "keyed_record_table_assert.svh"

  `KRT_ASSERT_NOW(a_count_range, 1'b1, count <= krt_pkg::CNT_W'(krt_pkg::CAPACITY), "record count beyond capacity")
  `KRT_ASSERT_NEXT(a_count_hold, !(can_step && last_step), $stable(count), "record count changed outside the end of a turn")
  `KRT_ASSERT_NEXT(a_turn_length, busy && !(can_step && last_step), busy, "ring turn ended early")

endmodule
